>>> src/csu_pkg.sv
// ----------------------------------------------------------------------------
// csu_pkg
// shared types, constants and helpers of the counting semaphore unit
// ----------------------------------------------------------------------------
package csu_pkg;

  localparam int SEM_SLOTS  = 4;
  localparam int WAIT_DEPTH = 8;

  localparam int SLOT_W   = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int POS_W    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FILL_W   = $clog2(WAIT_DEPTH + 1);
  localparam int QDEPTH   = SEM_SLOTS * WAIT_DEPTH;
  localparam int QADDR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W    = 16;
  localparam int TID_W    = 16;
  localparam int IDX_W    = 3;
  localparam int ACT_W    = 3;
  localparam int CFG_W    = 64;
  localparam int PADDR_W  = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSEM    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_QFULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_ACTIVE = 2'd0,
    REG_INIT   = 2'd1,
    REG_MAX    = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_WAKE
  } state_t;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] sem_index;
    logic [TID_W-1:0] thread_id;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic             caller_blocked;
    logic             woke_valid;
    logic [TID_W-1:0] woke_thread;
  } rsp_t;

  typedef struct packed {
    logic [ACT_W-1:0] active;
    logic [CFG_W-1:0] init_values;
    logic [CFG_W-1:0] max_values;
  } cfg_t;

  // per-semaphore record kept in the descriptor memory
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [POS_W-1:0]  head;
    logic [POS_W-1:0]  tail;
    logic [FILL_W-1:0] fill;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } desc_rd_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    desc_t             data;
  } desc_wr_t;

  typedef struct packed {
    logic               en;
    logic [QADDR_W-1:0] addr;
  } q_rd_t;

  typedef struct packed {
    logic               en;
    logic [QADDR_W-1:0] addr;
    logic [TID_W-1:0]   data;
  } q_wr_t;

  function automatic logic [CNT_W-1:0] lane16(logic [CFG_W-1:0] packed_v,
                                              logic [SLOT_W-1:0] slot);
    return packed_v[slot*CNT_W +: CNT_W];
  endfunction

  function automatic logic [POS_W-1:0] next_pos(logic [POS_W-1:0] p);
    logic [POS_W:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= (POS_W+1)'(WAIT_DEPTH)) ? '0 : n[POS_W-1:0];
  endfunction

  function automatic logic [QADDR_W-1:0] q_addr(logic [SLOT_W-1:0] slot,
                                                logic [POS_W-1:0] pos);
    return QADDR_W'(QADDR_W'(slot) * QADDR_W'(WAIT_DEPTH) + QADDR_W'(pos));
  endfunction

endpackage

>>> src/csu_regs.sv
// ----------------------------------------------------------------------------
// csu_regs
// apb-style configuration registers
// ----------------------------------------------------------------------------
module csu_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csu_pkg::PADDR_W-1:0]   paddr,
  input  logic [csu_pkg::CFG_W-1:0]     pwdata,
  output logic [csu_pkg::CFG_W-1:0]     prdata,
  output csu_pkg::cfg_t                 cfg,
  output logic                          load_counts
);

  logic                          wr_stb;
  csu_pkg::reg_idx_t             sel;
  logic [csu_pkg::ACT_W-1:0]     active;
  logic [csu_pkg::CFG_W-1:0]     init_values;
  logic [csu_pkg::CFG_W-1:0]     max_values;

  assign sel    = csu_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_stb = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= csu_pkg::ACT_W'(4);
      init_values <= '0;
      max_values  <= '0;
    end else if (wr_stb) begin
      case (sel)
        csu_pkg::REG_ACTIVE: active      <= pwdata[csu_pkg::ACT_W-1:0];
        csu_pkg::REG_INIT:   init_values <= pwdata;
        csu_pkg::REG_MAX:    max_values  <= pwdata;
        default: ;
      endcase
    end
  end

  // a write of the start values reloads every count
  assign load_counts = wr_stb && (sel == csu_pkg::REG_INIT);

  always_comb begin
    case (sel)
      csu_pkg::REG_ACTIVE: prdata = csu_pkg::CFG_W'(active);
      csu_pkg::REG_INIT:   prdata = init_values;
      csu_pkg::REG_MAX:    prdata = max_values;
      default:             prdata = '0;
    endcase
  end

  assign cfg.active      = active;
  assign cfg.init_values = init_values;
  assign cfg.max_values  = max_values;

endmodule

>>> src/csu_desc_store.sv
// ----------------------------------------------------------------------------
// csu_desc_store
// descriptor memory with per-entry valid flags for reset and count reload
// ----------------------------------------------------------------------------
module csu_desc_store (
  input  logic                       clk,
  input  logic                       rst,
  input  csu_pkg::desc_rd_t          rd,
  input  csu_pkg::desc_wr_t          wr,
  input  logic                       load_counts,
  input  logic [csu_pkg::CFG_W-1:0]  init_values,
  output csu_pkg::desc_t             rd_desc
);

  csu_pkg::desc_t                    mem [csu_pkg::SEM_SLOTS];
  csu_pkg::desc_t                    rd_q;
  logic [csu_pkg::SLOT_W-1:0]        rd_slot;
  logic [csu_pkg::SEM_SLOTS-1:0]     q_valid;
  logic [csu_pkg::SEM_SLOTS-1:0]     c_valid;
  logic                              rd_qv;
  logic                              rd_cv;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q    <= mem[rd.addr];
      rd_slot <= rd.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= '0;
      c_valid <= '0;
      rd_qv   <= 1'b0;
      rd_cv   <= 1'b0;
    end else begin
      if (load_counts) begin
        c_valid <= '0;
      end else if (wr.en) begin
        c_valid[wr.addr] <= 1'b1;
      end
      if (wr.en) begin
        q_valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_qv <= q_valid[rd.addr];
        rd_cv <= c_valid[rd.addr] && !load_counts;
      end
    end
  end

  // entries never written read as zero queues; stale counts come from config
  always_comb begin
    rd_desc.count = rd_cv ? rd_q.count : csu_pkg::lane16(init_values, rd_slot);
    rd_desc.head  = rd_qv ? rd_q.head : '0;
    rd_desc.tail  = rd_qv ? rd_q.tail : '0;
    rd_desc.fill  = rd_qv ? rd_q.fill : '0;
  end

endmodule

>>> src/csu_queue_ram.sv
// ----------------------------------------------------------------------------
// csu_queue_ram
// wait queue storage, one region per semaphore, registered read
// ----------------------------------------------------------------------------
module csu_queue_ram (
  input  logic                       clk,
  input  csu_pkg::q_rd_t             rd,
  input  csu_pkg::q_wr_t             wr,
  output logic [csu_pkg::TID_W-1:0]  rd_data
);

  logic [csu_pkg::TID_W-1:0] mem [csu_pkg::QDEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

>>> src/csu_core.sv
// ----------------------------------------------------------------------------
// csu_core
// request sequencer: read descriptor, decide, write back, queue access
// ----------------------------------------------------------------------------
module csu_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  csu_pkg::req_t              req_word,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output csu_pkg::rsp_t              rsp_word,
  input  csu_pkg::cfg_t              cfg,
  output csu_pkg::desc_rd_t          d_rd,
  output csu_pkg::desc_wr_t          d_wr,
  input  csu_pkg::desc_t             desc,
  output csu_pkg::q_rd_t             q_rd,
  output csu_pkg::q_wr_t             q_wr,
  input  logic [csu_pkg::TID_W-1:0]  q_data
);

  csu_pkg::state_t              state;
  csu_pkg::state_t              state_next;
  csu_pkg::req_t                req_q;
  csu_pkg::rsp_t                rsp_q;
  csu_pkg::rsp_t                rsp_next;
  logic                         rsp_load;
  logic                         slot_free;
  logic                         accept;
  logic [csu_pkg::SLOT_W-1:0]   slot;
  logic [csu_pkg::ACT_W-1:0]    limit;
  logic                         bad_idx;
  logic [csu_pkg::CNT_W-1:0]    max_v;
  logic                         q_full;
  logic                         q_empty;
  logic                         do_wake;
  logic                         do_block;
  logic                         modifies;
  csu_pkg::desc_t               desc_new;
  csu_pkg::status_t             st;

  assign slot      = req_q.sem_index[csu_pkg::SLOT_W-1:0];
  assign slot_free = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign limit     = (cfg.active > csu_pkg::ACT_W'(csu_pkg::SEM_SLOTS))
                   ? csu_pkg::ACT_W'(csu_pkg::SEM_SLOTS) : cfg.active;
  assign bad_idx   = req_q.sem_index >= limit;
  assign max_v     = csu_pkg::lane16(cfg.max_values, slot);
  assign q_full    = desc.fill >= csu_pkg::FILL_W'(csu_pkg::WAIT_DEPTH);
  assign q_empty   = desc.fill == '0;

  // decision on the descriptor that came back from memory
  always_comb begin
    desc_new = desc;
    st       = csu_pkg::ST_OK;
    do_wake  = 1'b0;
    do_block = 1'b0;
    modifies = 1'b0;
    if (bad_idx) begin
      st = csu_pkg::ST_NOSEM;
    end else if (!req_q.req_type) begin
      if (desc.count != '0) begin
        desc_new.count = desc.count - 1'b1;
        modifies       = 1'b1;
      end else if (q_full) begin
        st = csu_pkg::ST_QFULL;
      end else begin
        desc_new.tail = csu_pkg::next_pos(desc.tail);
        desc_new.fill = desc.fill + 1'b1;
        modifies      = 1'b1;
        do_block      = 1'b1;
      end
    end else begin
      if (desc.count >= max_v) begin
        st = csu_pkg::ST_OVERFLOW;
      end else if (q_empty) begin
        desc_new.count = desc.count + 1'b1;
        modifies       = 1'b1;
      end else begin
        desc_new.head = csu_pkg::next_pos(desc.head);
        desc_new.fill = desc.fill - 1'b1;
        modifies      = 1'b1;
        do_wake       = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      csu_pkg::S_IDLE: if (accept) state_next = csu_pkg::S_EVAL;
      csu_pkg::S_EVAL: begin
        if (do_wake) begin
          state_next = csu_pkg::S_WAKE;
        end else if (slot_free) begin
          state_next = csu_pkg::S_IDLE;
        end
      end
      csu_pkg::S_WAKE: if (slot_free) state_next = csu_pkg::S_IDLE;
      default: state_next = csu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready          = 1'b0;
    d_rd.en            = 1'b0;
    d_rd.addr          = req_word.sem_index[csu_pkg::SLOT_W-1:0];
    d_wr.en            = 1'b0;
    d_wr.addr          = slot;
    d_wr.data          = desc_new;
    q_rd.en            = 1'b0;
    q_rd.addr          = csu_pkg::q_addr(slot, desc.head);
    q_wr.en            = 1'b0;
    q_wr.addr          = csu_pkg::q_addr(slot, desc.tail);
    q_wr.data          = req_q.thread_id;
    rsp_load           = 1'b0;
    rsp_next           = '0;
    rsp_next.status    = st;
    case (state)
      csu_pkg::S_IDLE: begin
        req_ready = 1'b1;
        d_rd.en   = req_valid;
      end
      csu_pkg::S_EVAL: begin
        if (do_wake) begin
          d_wr.en = 1'b1;
          q_rd.en = 1'b1;
        end else if (slot_free) begin
          d_wr.en                 = modifies;
          q_wr.en                 = do_block;
          rsp_load                = 1'b1;
          rsp_next.caller_blocked = do_block;
        end
      end
      csu_pkg::S_WAKE: begin
        if (slot_free) begin
          rsp_load             = 1'b1;
          rsp_next.status      = csu_pkg::ST_OK;
          rsp_next.woke_valid  = 1'b1;
          rsp_next.woke_thread = q_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= csu_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_word;
    end
    if (rsp_load) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_word = rsp_q;

  a_block_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && rsp_next.caller_blocked) |->
      (rsp_next.status == csu_pkg::ST_OK && !rsp_next.woke_valid))
    else $error("blocked word carries a fault or a wake");

  a_no_thread: assert property (@(posedge clk) disable iff (rst)
    (rsp_load && !rsp_next.woke_valid) |-> (rsp_next.woke_thread == '0))
    else $error("thread id without wake");

  a_qwr_room: assert property (@(posedge clk) disable iff (rst)
    q_wr.en |-> (desc.fill < csu_pkg::FILL_W'(csu_pkg::WAIT_DEPTH)))
    else $error("queue write into full queue");

  a_wake_has: assert property (@(posedge clk) disable iff (rst)
    q_rd.en |-> (!q_empty && state == csu_pkg::S_EVAL))
    else $error("queue read from empty queue");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    (d_wr.en && state == csu_pkg::S_EVAL) |=> (state != csu_pkg::S_EVAL))
    else $error("descriptor written twice for one request");

endmodule

>>> src/counting_semaphore_unit.sv
// ----------------------------------------------------------------------------
// counting_semaphore_unit
// table of counting semaphores with per-semaphore fifo wait queues
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            word
// req       in         req_valid/req_ready  req_t: req_type, sem_index, thread_id
// rsp       out        rsp_valid/rsp_ready  rsp_t: status, caller_blocked, woke_*
// apb       in/out     psel/penable/pready  64-bit registers at byte address 8*i
//
// a request passes a descriptor memory read, then decide and write back, and
// a signal that wakes a waiter adds a wait queue memory read
// the single descriptor read-modify-write per request sets the rate
// reset clears the state machine and the valid flags of the descriptor
// memory, so no clearing pass is needed; counts read from initial_values
// a held result stalls the finishing step only; the next request is taken
// once the result of the previous one has been loaded into the result register
//
module counting_semaphore_unit (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csu_pkg::PADDR_W-1:0]   paddr,
  input  logic [csu_pkg::CFG_W-1:0]     pwdata,
  output logic [csu_pkg::CFG_W-1:0]     prdata,
  output logic                          pready,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  csu_pkg::req_t                 req_word,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output csu_pkg::rsp_t                 rsp_word
);

  csu_pkg::cfg_t                 cfg;
  logic                          load_counts;
  csu_pkg::desc_rd_t             d_rd;
  csu_pkg::desc_wr_t             d_wr;
  csu_pkg::desc_t                desc;
  csu_pkg::q_rd_t                q_rd;
  csu_pkg::q_wr_t                q_wr;
  logic [csu_pkg::TID_W-1:0]     q_data;

  // the register port never waits
  assign pready = 1'b1;

  // configuration registers; a write of initial_values reloads all counts
  csu_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .cfg         (cfg),
    .load_counts (load_counts)
  );

  // per-semaphore count, head, tail and fill
  csu_desc_store u_desc (
    .clk         (clk),
    .rst         (rst),
    .rd          (d_rd),
    .wr          (d_wr),
    .load_counts (load_counts),
    .init_values (cfg.init_values),
    .rd_desc     (desc)
  );

  // blocked thread ids, one region of WAIT_DEPTH words per semaphore
  csu_queue_ram u_queue (
    .clk     (clk),
    .rd      (q_rd),
    .wr      (q_wr),
    .rd_data (q_data)
  );

  // request sequencer and result register
  csu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word),
    .cfg       (cfg),
    .d_rd      (d_rd),
    .d_wr      (d_wr),
    .desc      (desc),
    .q_rd      (q_rd),
    .q_wr      (q_wr),
    .q_data    (q_data)
  );

endmodule

>>> tb/csu_tb_pkg.sv
// ----------------------------------------------------------------------------
// csu_tb_pkg
// request codes shared by the semaphore unit checker and its test top
// ----------------------------------------------------------------------------
package csu_tb_pkg;

  // meaning of the req_type bit of a request word
  typedef enum logic {
    OP_WAIT   = 1'b0,
    OP_SIGNAL = 1'b1
  } req_op_t;

endpackage

>>> tb/csu_checker.sv
// ----------------------------------------------------------------------------
// csu_checker
// tracks the semaphore table from register writes and accepted requests,
// predicts the result word of each request and compares it in order
// ----------------------------------------------------------------------------
module csu_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csu_pkg::PADDR_W-1:0] paddr,
  input  logic [csu_pkg::CFG_W-1:0]   pwdata,
  input  logic                        pready,
  input  logic                        req_valid,
  input  logic                        req_ready,
  input  csu_pkg::req_t               req_word,
  input  logic                        rsp_valid,
  input  logic                        rsp_ready,
  input  csu_pkg::rsp_t               rsp_word,
  output int                          errors,
  output int                          open_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  import csu_pkg::*;
  import csu_tb_pkg::*;

  logic [ACT_W-1:0] act_n;
  logic [CFG_W-1:0] init_lanes;
  logic [CFG_W-1:0] max_lanes;
  logic [CNT_W-1:0] count_m [SEM_SLOTS];
  logic [TID_W-1:0] waiters [SEM_SLOTS][WAIT_DEPTH];
  int               head_m  [SEM_SLOTS];
  int               tail_m  [SEM_SLOTS];
  int               fill_m  [SEM_SLOTS];

  rsp_t outcomes [$];
  rsp_t want;
  int   bad_cnt = 0;
  int   open_r  = 0;
  int   seen    = 0;

  assign errors   = bad_cnt;
  assign open_cnt = open_r;

  task automatic report_bad(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, seen, msg);
    bad_cnt++;
  endtask

  // applies one request to the tracked table, returns the word it should give
  function automatic rsp_t sem_outcome(input req_t r);
    rsp_t             o;
    int               lim;
    int               s;
    logic [CNT_W-1:0] ceiling;
    o        = '0;
    o.status = ST_OK;
    lim      = (int'(act_n) < SEM_SLOTS) ? int'(act_n) : SEM_SLOTS;
    s        = int'(r.sem_index);
    if (s >= lim) begin
      o.status = ST_NOSEM;
    end else if (req_op_t'(r.req_type) == OP_WAIT) begin
      if (count_m[s] != '0) begin
        count_m[s] = count_m[s] - 1'b1;
      end else if (fill_m[s] >= WAIT_DEPTH) begin
        o.status = ST_QFULL;
      end else begin
        waiters[s][tail_m[s]] = r.thread_id;
        tail_m[s] = (tail_m[s] + 1) % WAIT_DEPTH;
        fill_m[s]++;
        o.caller_blocked = 1'b1;
      end
    end else begin
      ceiling = max_lanes[s*CNT_W +: CNT_W];
      if (count_m[s] >= ceiling) begin
        o.status = ST_OVERFLOW;
      end else if (fill_m[s] == 0) begin
        count_m[s] = count_m[s] + 1'b1;
      end else begin
        o.woke_valid  = 1'b1;
        o.woke_thread = waiters[s][head_m[s]];
        head_m[s] = (head_m[s] + 1) % WAIT_DEPTH;
        fill_m[s]--;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      act_n      = 3'd4;
      init_lanes = '0;
      max_lanes  = '0;
      for (int s = 0; s < SEM_SLOTS; s++) begin
        count_m[s] = '0;
        head_m[s]  = 0;
        tail_m[s]  = 0;
        fill_m[s]  = 0;
      end
      outcomes.delete();
      open_r <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:3]))
          REG_ACTIVE: act_n = pwdata[ACT_W-1:0];
          REG_INIT: begin
            // loading the start counts resets every value, queues stay
            init_lanes = pwdata;
            for (int s = 0; s < SEM_SLOTS; s++) count_m[s] = init_lanes[s*CNT_W +: CNT_W];
          end
          REG_MAX: max_lanes = pwdata;
          default: ;
        endcase
      end
      if (req_valid && req_ready) outcomes.push_back(sem_outcome(req_word));
      if (rsp_valid && rsp_ready) begin
        seen++;
        if (outcomes.size() == 0) begin
          report_bad($sformatf("unexpected word %h", rsp_word));
        end else begin
          want = outcomes.pop_front();
          if (rsp_word.status !== want.status)
            report_bad($sformatf("status %0d, want %0d", rsp_word.status, want.status));
          if (rsp_word.caller_blocked !== want.caller_blocked)
            report_bad($sformatf("caller_blocked %b, want %b",
                                 rsp_word.caller_blocked, want.caller_blocked));
          if (rsp_word.woke_valid !== want.woke_valid)
            report_bad($sformatf("woke_valid %b, want %b",
                                 rsp_word.woke_valid, want.woke_valid));
          if (rsp_word.woke_thread !== want.woke_thread)
            report_bad($sformatf("woke_thread %h, want %h",
                                 rsp_word.woke_thread, want.woke_thread));
        end
      end
      open_r <= outcomes.size();
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives the counting semaphore unit with a directed opening and random
// request phases under changing register settings; a side checker predicts
// every result word and the top gives the verdict from its error count
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csu_pkg::*;
  import csu_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles without any accepted word
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 125;
  localparam int IDLE_PCT    = 13;
  localparam int CALM_PHASE  = 6;     // phase run with no idling on either side

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [PADDR_W-1:0]   paddr     = '0;
  logic [CFG_W-1:0]     pwdata    = '0;
  logic [CFG_W-1:0]     prdata;
  logic                 pready;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req_word  = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp_word;

  int                   fail_cnt;
  int                   open_cnt;
  int                   stall_cycles = 0;
  bit                   calm = 1'b0;

  // stimulus-side view of the settings, only used to aim the indices
  int                   cur_limit;
  int                   wait_pct;
  int                   act_pick;
  logic [CFG_W-1:0]     lanes;

  always #1 clk = ~clk;

  counting_semaphore_unit u_top (.*);

  csu_checker u_chk (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_word (req_word),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_word (rsp_word),
    .errors   (fail_cnt),
    .open_cnt (open_cnt)
  );

  // result side back-pressure, switched off during the calm phase
  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request word; valid stays up across back-to-back words
  task automatic put_req(input req_op_t op, input int idx, input logic [TID_W-1:0] tid);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= '{req_type: op, sem_index: IDX_W'(idx), thread_id: tid};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // setup cycle then access cycle, register lands at the access edge
  task automatic write_reg(input reg_idx_t r, input logic [CFG_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 3'b000});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // stop issuing and wait until every predicted word has come back
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (open_cnt != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_active(input logic [ACT_W-1:0] a);
    write_reg(REG_ACTIVE, CFG_W'(a));
    cur_limit = (int'(a) < SEM_SLOTS) ? int'(a) : SEM_SLOTS;
  endtask

  // one 16-bit lane: extremes, small counts that drain to zero, or anything
  function automatic logic [CNT_W-1:0] pick_lane();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 16'hFFFE;
      3, 4, 5: return CNT_W'($urandom_range(4));
      default: return CNT_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_lanes();
    logic [CFG_W-1:0] v;
    v = '0;
    for (int s = 0; s < 4; s++) v[s*CNT_W +: CNT_W] = pick_lane();
    return v;
  endfunction

  initial begin
    cur_limit = SEM_SLOTS;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed opening, reset settings: 4 semaphores, counts 0, max 0 ----
    put_req(OP_WAIT,   0, 16'hFFFF);  // count zero, caller queued
    put_req(OP_SIGNAL, 0, 16'h0000);  // max 0 means overflow even with a waiter
    put_req(OP_WAIT,   7, 16'h1234);  // top index, no such semaphore
    put_req(OP_SIGNAL, 4, 16'h4321);  // first index past the table
    settle();

    // sem0 max ffff, sem1 max 3, sem2 max 5, sem3 max ffff
    write_reg(REG_MAX,  64'hFFFF_0005_0003_FFFF);
    // counts: sem0 0, sem1 1, sem2 0, sem3 ffff; sem0 keeps its waiter
    write_reg(REG_INIT, 64'hFFFF_0000_0001_0000);

    put_req(OP_SIGNAL, 0, 16'h0000);  // releases the waiter left from before
    put_req(OP_WAIT,   1, 16'h0001);  // takes the last unit
    put_req(OP_WAIT,   1, 16'hAAAA);  // blocks
    put_req(OP_SIGNAL, 1, 16'h5555);  // wakes aaaa, count stays 0
    for (int i = 1; i <= WAIT_DEPTH; i++) put_req(OP_WAIT, 2, TID_W'(i));
    put_req(OP_WAIT,   2, 16'h0009);  // queue full, caller not queued
    put_req(OP_SIGNAL, 2, 16'h0000);  // oldest waiter comes out first
    put_req(OP_WAIT,   3, 16'h0000);  // ffff down to fffe
    put_req(OP_SIGNAL, 3, 16'h0000);  // back up to ffff
    put_req(OP_SIGNAL, 3, 16'h0000);  // at the 16-bit ceiling
    settle();

    set_active(3'd7);                 // above the table size, clamps to all slots
    put_req(OP_WAIT,   3, 16'h5555);
    put_req(OP_WAIT,   5, 16'h0000);
    settle();
    set_active(3'd0);                 // nothing defined
    put_req(OP_SIGNAL, 0, 16'hFFFF);
    put_req(OP_WAIT,   3, 16'h8000);

    // ---- random phases: mixed settings, wait-heavy or signal-heavy traffic ----
    for (int p = 0; p < PHASES; p++) begin
      settle();
      calm <= (p == CALM_PHASE);
      if (p == 0 || $urandom_range(2) != 0) begin
        act_pick = $urandom_range(9);
        case (act_pick)
          0:       set_active(3'd0);
          1:       set_active(3'd7);
          2:       set_active(ACT_W'($urandom_range(6, 5)));
          3, 4:    set_active(ACT_W'($urandom_range(3, 1)));
          default: set_active(3'd4);
        endcase
      end
      if (p == 0 || $urandom_range(2) != 0) begin
        lanes = pick_lanes();
        write_reg(REG_MAX, lanes);
      end
      if (p == 0 || $urandom_range(2) != 0) begin
        lanes = pick_lanes();
        write_reg(REG_INIT, lanes);
      end
      case ($urandom_range(2))
        0:       wait_pct = 25;
        1:       wait_pct = 50;
        default: wait_pct = 75;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // mostly defined semaphores, a tenth anywhere in the index range
        if (cur_limit > 0 && $urandom_range(9) != 0)
          put_req(($urandom_range(99) < wait_pct) ? OP_WAIT : OP_SIGNAL,
                  $urandom_range(cur_limit - 1), TID_W'($urandom));
        else
          put_req(($urandom_range(99) < wait_pct) ? OP_WAIT : OP_SIGNAL,
                  $urandom_range(7), TID_W'($urandom));
      end
    end

    // ---- drain and verdict ----
    settle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
